// ===== hw/rtl/rbia_pkg.sv =====
// ----------------------------------------------------------------------------
// rbia_pkg
// Shared widths, codes and controller/datapath types of the indexed ring
// buffer.
// ----------------------------------------------------------------------------
package rbia_pkg;

    // Default sizing of the store
    localparam int DEF_CAPACITY   = 64;
    localparam int DEF_WORD_WIDTH = 32;

    // Request and result field widths
    localparam int OP_W     = 3;
    localparam int INDEX_W  = 7;
    localparam int INDEX2_W = 6;
    localparam int SPAN_W   = 7;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int FOUND_W  = 6;
    localparam int COUNT_W  = 7;

    typedef enum logic [OP_W-1:0] {
        OP_GET        = 3'd0,
        OP_SET        = 3'd1,
        OP_INSERT     = 3'd2,
        OP_REMOVE     = 3'd3,
        OP_EXCHANGE   = 3'd4,
        OP_FIND_FIRST = 3'd5,
        OP_FIND_LAST  = 3'd6,
        OP_CLEAR      = 3'd7
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_RANGE     = 2'd1,
        ST_FULL      = 2'd2,
        ST_NOT_FOUND = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_WALK,
        S_PUT,
        S_FIND,
        S_XREAD,
        S_XWRITE_A,
        S_XWRITE_B,
        S_RESP
    } state_t;

    // Memory port command for one cycle
    typedef enum logic [2:0] {
        MC_NONE,
        MC_RD_IDX,
        MC_RD_IDX2,
        MC_WR_VAL_IDX,
        MC_WR_VAL_PUT,
        MC_WR_A,
        MC_WR_B
    } mem_cmd_t;

    typedef struct packed {
        logic     capture;
        logic     walk_init;
        logic     step;
        mem_cmd_t mem;
        logic     commit;
        status_t  status;
    } ctrl_cmd_t;

    typedef struct packed {
        op_t  op;
        logic pos_ok;
        logic pos2_ok;
        logic ins_ok;
        logic full;
        logic span_ok;
        logic rem_zero;
        logic cmp_pending;
        logic hit;
        logic out_free;
    } dp_status_t;

endpackage

// ===== hw/rtl/rbia_if.sv =====
// ----------------------------------------------------------------------------
// rbia_req_if / rbia_rsp_if
// Valid/ready channels carrying requests into and results out of the
// indexed ring buffer.
// ----------------------------------------------------------------------------
interface rbia_req_if import rbia_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [OP_W-1:0]     op;
    logic [INDEX_W-1:0]  index;
    logic [INDEX2_W-1:0] second_index;
    logic [SPAN_W-1:0]   span_length;
    logic [VALUE_W-1:0]  value_in;

    modport source (
        output valid, op, index, second_index, span_length, value_in,
        input  ready
    );
    modport sink (
        input  valid, op, index, second_index, span_length, value_in,
        output ready
    );
endinterface

interface rbia_rsp_if import rbia_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [VALUE_W-1:0]  value_out;
    logic [FOUND_W-1:0]  found_index;
    logic [COUNT_W-1:0]  entry_count;

    modport source (
        output valid, status, value_out, found_index, entry_count,
        input  ready
    );
    modport sink (
        input  valid, status, value_out, found_index, entry_count,
        output ready
    );
endinterface

// ===== hw/rtl/rbia_controller.sv =====
// ----------------------------------------------------------------------------
// rbia_controller
// Sequencer of the indexed ring buffer: checks each request, steps the
// datapath through reads, shifts and searches, and hands off the result.
// ----------------------------------------------------------------------------
module rbia_controller import rbia_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       req_valid,
    output logic       req_ready,
    input  dp_status_t dp,
    output ctrl_cmd_t  cmd
);

    state_t  state_reg;
    state_t  state_next;
    status_t status_reg;
    status_t status_next;

    // State and result status registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            status_reg <= ST_OK;
        end
        else
        begin
            state_reg  <= state_next;
            status_reg <= status_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next  = state_reg;
        status_next = status_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                status_next = ST_OK;
                state_next  = S_RESP;
                unique case (dp.op)
                    OP_GET, OP_SET:
                    begin
                        if (!dp.pos_ok)
                        begin
                            status_next = ST_RANGE;
                        end
                    end
                    OP_INSERT:
                    begin
                        priority if (!dp.ins_ok)
                        begin
                            status_next = ST_RANGE;
                        end
                        else if (dp.full)
                        begin
                            status_next = ST_FULL;
                        end
                        else
                        begin
                            state_next = S_WALK;
                        end
                    end
                    OP_REMOVE:
                    begin
                        if (dp.pos_ok)
                        begin
                            state_next = S_WALK;
                        end
                        else
                        begin
                            status_next = ST_RANGE;
                        end
                    end
                    OP_EXCHANGE:
                    begin
                        if (dp.pos_ok && dp.pos2_ok)
                        begin
                            state_next = S_XREAD;
                        end
                        else
                        begin
                            status_next = ST_RANGE;
                        end
                    end
                    OP_FIND_FIRST, OP_FIND_LAST:
                    begin
                        if (dp.span_ok)
                        begin
                            state_next = S_FIND;
                        end
                        else
                        begin
                            status_next = ST_RANGE;
                        end
                    end
                    OP_CLEAR:
                    begin
                        state_next = S_RESP;
                    end
                endcase
            end
            S_WALK:
            begin
                if (dp.rem_zero)
                begin
                    state_next = (dp.op == OP_INSERT) ? S_PUT : S_RESP;
                end
            end
            S_PUT:
            begin
                state_next = S_RESP;
            end
            S_FIND:
            begin
                priority if (dp.hit)
                begin
                    status_next = ST_OK;
                    state_next  = S_RESP;
                end
                else if (dp.rem_zero && !dp.cmp_pending)
                begin
                    status_next = ST_NOT_FOUND;
                    state_next  = S_RESP;
                end
                else
                begin
                    state_next = S_FIND;
                end
            end
            S_XREAD:
            begin
                state_next = S_XWRITE_A;
            end
            S_XWRITE_A:
            begin
                state_next = S_XWRITE_B;
            end
            S_XWRITE_B:
            begin
                state_next = S_RESP;
            end
            S_RESP:
            begin
                if (dp.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Commands to the datapath
    always_comb
    begin
        req_ready     = 1'b0;
        cmd.capture   = 1'b0;
        cmd.walk_init = 1'b0;
        cmd.step      = 1'b0;
        cmd.mem       = MC_NONE;
        cmd.commit    = 1'b0;
        cmd.status    = status_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                req_ready   = 1'b1;
                cmd.capture = req_valid;
            end
            S_DECODE:
            begin
                unique case (dp.op)
                    OP_GET:
                    begin
                        cmd.mem = dp.pos_ok ? MC_RD_IDX : MC_NONE;
                    end
                    OP_SET:
                    begin
                        cmd.mem = dp.pos_ok ? MC_WR_VAL_IDX : MC_NONE;
                    end
                    OP_INSERT:
                    begin
                        cmd.walk_init = dp.ins_ok && !dp.full;
                    end
                    OP_REMOVE:
                    begin
                        cmd.walk_init = dp.pos_ok;
                    end
                    OP_EXCHANGE:
                    begin
                        cmd.mem = (dp.pos_ok && dp.pos2_ok) ? MC_RD_IDX : MC_NONE;
                    end
                    OP_FIND_FIRST, OP_FIND_LAST:
                    begin
                        cmd.walk_init = dp.span_ok;
                    end
                    OP_CLEAR:
                    begin
                        cmd.mem = MC_NONE;
                    end
                endcase
            end
            S_WALK:
            begin
                cmd.step = !dp.rem_zero;
            end
            S_PUT:
            begin
                cmd.mem = MC_WR_VAL_PUT;
            end
            S_FIND:
            begin
                cmd.step = !dp.rem_zero && !dp.hit;
            end
            S_XREAD:
            begin
                cmd.mem = MC_RD_IDX2;
            end
            S_XWRITE_A:
            begin
                cmd.mem = MC_WR_A;
            end
            S_XWRITE_B:
            begin
                cmd.mem = MC_WR_B;
            end
            S_RESP:
            begin
                cmd.commit = dp.out_free;
            end
            default:
            begin
                cmd.mem = MC_NONE;
            end
        endcase
    end

    // A result is only handed off when the output register can take it
    a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> dp.out_free)
        else $error("result committed while output register is occupied");

    // A walk step never overlaps a single-entry memory command
    a_step_alone: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step |-> (cmd.mem == MC_NONE) && !cmd.commit)
        else $error("walk step overlaps another memory command");

endmodule

// ===== hw/rtl/rbia_datapath.sv =====
// ----------------------------------------------------------------------------
// rbia_datapath
// Storage, pointers and result register of the indexed ring buffer: the
// circular word memory, head and count, the walk pointers used for shifts
// and searches, and the output register.
// ----------------------------------------------------------------------------
module rbia_datapath import rbia_pkg::*;
#(
    parameter int CAPACITY   = DEF_CAPACITY,
    parameter int WORD_WIDTH = DEF_WORD_WIDTH
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  ctrl_cmd_t           cmd,
    output dp_status_t          status,
    input  logic [OP_W-1:0]     req_op,
    input  logic [INDEX_W-1:0]  req_index,
    input  logic [INDEX2_W-1:0] req_second_index,
    input  logic [SPAN_W-1:0]   req_span_length,
    input  logic [VALUE_W-1:0]  req_value_in,
    input  logic                rsp_ready,
    output logic                rsp_valid,
    output logic [STATUS_W-1:0] rsp_status,
    output logic [VALUE_W-1:0]  rsp_value_out,
    output logic [FOUND_W-1:0]  rsp_found_index,
    output logic [COUNT_W-1:0]  rsp_entry_count
);

    localparam int PW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int AW = ((CW > INDEX_W) ? CW : INDEX_W) + 1;
    localparam int SW = AW + 1;

    // Physical slot of a logical offset from a base pointer
    function automatic logic [PW-1:0] slot_of(input logic [PW-1:0] base,
                                              input logic [AW-1:0] off);
        logic [SW-1:0] sum;
        sum = SW'(base) + SW'(off);
        if (sum >= SW'(CAPACITY))
        begin
            sum = sum - SW'(CAPACITY);
        end
        return sum[PW-1:0];
    endfunction

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        return (p == PW'(CAPACITY - 1)) ? '0 : p + PW'(1);
    endfunction

    function automatic logic [PW-1:0] ptr_dec(input logic [PW-1:0] p);
        return (p == '0) ? PW'(CAPACITY - 1) : p - PW'(1);
    endfunction

    // Word store
    logic [WORD_WIDTH-1:0] mem [CAPACITY];

    // Request operands
    op_t                   op_reg;
    logic [INDEX_W-1:0]    idx_reg;
    logic [INDEX2_W-1:0]   idx2_reg;
    logic [SPAN_W-1:0]     span_reg;
    logic [WORD_WIDTH-1:0] val_reg;

    // List state
    logic [PW-1:0] head_reg;
    logic [PW-1:0] head_next;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;

    // Walk state
    logic [PW-1:0] ppos_reg;
    logic [CW-1:0] lpos_reg;
    logic [CW-1:0] rem_reg;
    logic          up_reg;
    logic          left_reg;
    logic          pend_v_reg;
    logic [PW-1:0] pend_addr_reg;
    logic          cmp_v_reg;
    logic [CW-1:0] cmp_lpos_reg;

    // Read data and exchange holding word
    logic [WORD_WIDTH-1:0] rdata_reg;
    logic [WORD_WIDTH-1:0] tmp_reg;

    // Output register
    logic                out_valid_reg;
    logic [STATUS_W-1:0] out_status_reg;
    logic [VALUE_W-1:0]  out_value_reg;
    logic [FOUND_W-1:0]  out_found_reg;
    logic [COUNT_W-1:0]  out_count_reg;

    // Operand views and checks
    logic [AW-1:0] idx_a;
    logic [AW-1:0] idx2_a;
    logic [AW-1:0] span_a;
    logic [AW-1:0] cnt_a;
    logic [AW-1:0] last_a;
    logic          is_find;
    logic          hit;
    logic          out_free;
    logic          left_ins;
    logic          left_rem;
    logic [PW-1:0] slot_idx;
    logic [PW-1:0] slot_idx2;
    logic [PW-1:0] slot_cnt;
    logic [PW-1:0] slot_last;
    logic [PW-1:0] dst_ppos;

    // Walk setup
    logic [PW-1:0] init_ppos;
    logic [CW-1:0] init_lpos;
    logic [AW-1:0] init_rem;
    logic          init_up;
    logic          init_left;

    // Memory port
    logic                  rd_en;
    logic [PW-1:0]         rd_addr;
    logic                  wr_en;
    logic [PW-1:0]         wr_addr;
    logic [WORD_WIDTH-1:0] wr_data;
    logic                  cmd_writes;

    assign idx_a   = AW'(idx_reg);
    assign idx2_a  = AW'(idx2_reg);
    assign span_a  = AW'(span_reg);
    assign cnt_a   = AW'(count_reg);
    assign last_a  = idx_a + span_a - AW'(1);
    assign is_find = (op_reg == OP_FIND_FIRST) || (op_reg == OP_FIND_LAST);
    assign hit     = cmp_v_reg && (rdata_reg == val_reg);
    assign out_free = !out_valid_reg || rsp_ready;

    assign left_ins  = idx_a < (cnt_a - idx_a);
    assign left_rem  = idx_a < (cnt_a - AW'(1) - idx_a);
    assign slot_idx  = slot_of(head_reg, idx_a);
    assign slot_idx2 = slot_of(head_reg, idx2_a);
    assign slot_cnt  = slot_of(head_reg, cnt_a);
    assign slot_last = slot_of(head_reg, last_a);
    assign dst_ppos  = up_reg ? ptr_dec(ppos_reg) : ptr_inc(ppos_reg);

    // Status to the controller
    always_comb
    begin
        status.op          = op_reg;
        status.pos_ok      = idx_a < cnt_a;
        status.pos2_ok     = idx2_a < cnt_a;
        status.ins_ok      = idx_a <= cnt_a;
        status.full        = cnt_a >= AW'(CAPACITY);
        status.span_ok     = (idx_a <= cnt_a) && ((idx_a + span_a) <= cnt_a);
        status.rem_zero    = (rem_reg == '0);
        status.cmp_pending = cmp_v_reg;
        status.hit         = hit;
        status.out_free    = out_free;
    end

    // Pick the walk start: shifts move the shorter side, finds scan the span
    always_comb
    begin
        init_ppos = slot_idx;
        init_lpos = CW'(idx_a);
        init_rem  = span_a;
        init_up   = 1'b1;
        init_left = 1'b0;
        unique case (op_reg)
            OP_INSERT:
            begin
                init_left = left_ins;
                if (left_ins)
                begin
                    init_ppos = head_reg;
                    init_rem  = idx_a;
                    init_up   = 1'b1;
                end
                else
                begin
                    init_ppos = ptr_dec(slot_cnt);
                    init_rem  = cnt_a - idx_a;
                    init_up   = 1'b0;
                end
            end
            OP_REMOVE:
            begin
                init_left = left_rem;
                if (left_rem)
                begin
                    init_ppos = ptr_dec(slot_idx);
                    init_rem  = idx_a;
                    init_up   = 1'b0;
                end
                else
                begin
                    init_ppos = ptr_inc(slot_idx);
                    init_rem  = cnt_a - AW'(1) - idx_a;
                    init_up   = 1'b1;
                end
            end
            OP_FIND_LAST:
            begin
                init_ppos = slot_last;
                init_lpos = CW'(last_a);
                init_up   = 1'b0;
            end
            default:
            begin
                init_up = 1'b1;
            end
        endcase
    end

    // Memory port selection
    always_comb
    begin
        rd_en      = cmd.step;
        rd_addr    = ppos_reg;
        cmd_writes = 1'b0;
        wr_addr    = slot_idx;
        wr_data    = val_reg;
        unique case (cmd.mem)
            MC_NONE:
            begin
                cmd_writes = 1'b0;
            end
            MC_RD_IDX:
            begin
                rd_en   = 1'b1;
                rd_addr = slot_idx;
            end
            MC_RD_IDX2:
            begin
                rd_en   = 1'b1;
                rd_addr = slot_idx2;
            end
            MC_WR_VAL_IDX:
            begin
                cmd_writes = 1'b1;
            end
            MC_WR_VAL_PUT:
            begin
                cmd_writes = 1'b1;
                wr_addr    = dst_ppos;
            end
            MC_WR_A:
            begin
                cmd_writes = 1'b1;
                wr_data    = rdata_reg;
            end
            MC_WR_B:
            begin
                cmd_writes = 1'b1;
                wr_addr    = slot_idx2;
                wr_data    = tmp_reg;
            end
            default:
            begin
                cmd_writes = 1'b0;
            end
        endcase
        // Pending shift write owns the port
        if (pend_v_reg)
        begin
            wr_addr = pend_addr_reg;
            wr_data = rdata_reg;
        end
        wr_en = pend_v_reg || cmd_writes;
    end

    // Store write and registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rdata_reg <= mem[rd_addr];
        end
        if (cmd.mem == MC_RD_IDX2)
        begin
            tmp_reg <= rdata_reg;
        end
    end

    // Capture operands and walk pointers
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg   <= op_t'(req_op);
            idx_reg  <= req_index;
            idx2_reg <= req_second_index;
            span_reg <= req_span_length;
            val_reg  <= WORD_WIDTH'(req_value_in);
        end
        if (cmd.walk_init)
        begin
            ppos_reg <= init_ppos;
            lpos_reg <= init_lpos;
            rem_reg  <= CW'(init_rem);
            up_reg   <= init_up;
            left_reg <= init_left;
        end
        else if (cmd.step)
        begin
            ppos_reg      <= up_reg ? ptr_inc(ppos_reg) : ptr_dec(ppos_reg);
            lpos_reg      <= up_reg ? lpos_reg + CW'(1) : lpos_reg - CW'(1);
            rem_reg       <= rem_reg - CW'(1);
            pend_addr_reg <= dst_ppos;
            cmp_lpos_reg  <= lpos_reg;
        end
        if (cmd.commit)
        begin
            out_status_reg  <= cmd.status;
            out_value_reg   <= ((op_reg == OP_GET) && (cmd.status == ST_OK)) ?
                               VALUE_W'(rdata_reg) : '0;
            out_found_reg   <= (is_find && (cmd.status == ST_OK)) ?
                               FOUND_W'(cmp_lpos_reg) : '0;
            out_count_reg   <= COUNT_W'(count_next);
        end
    end

    // Head and count after a completed request
    always_comb
    begin
        head_next  = head_reg;
        count_next = count_reg;
        if (cmd.status == ST_OK)
        begin
            unique case (op_reg)
                OP_INSERT:
                begin
                    count_next = count_reg + CW'(1);
                    if (left_reg)
                    begin
                        head_next = ptr_dec(head_reg);
                    end
                end
                OP_REMOVE:
                begin
                    count_next = count_reg - CW'(1);
                    priority if (count_next == '0)
                    begin
                        head_next = '0;
                    end
                    else if (left_reg)
                    begin
                        head_next = ptr_inc(head_reg);
                    end
                    else
                    begin
                        head_next = head_reg;
                    end
                end
                OP_CLEAR:
                begin
                    count_next = '0;
                    head_next  = '0;
                end
                default:
                begin
                    count_next = count_reg;
                end
            endcase
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            count_reg     <= '0;
            pend_v_reg    <= 1'b0;
            cmp_v_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pend_v_reg <= cmd.step && !is_find;
            cmp_v_reg  <= cmd.step && is_find;
            if (cmd.commit)
            begin
                head_reg      <= head_next;
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign rsp_valid       = out_valid_reg;
    assign rsp_status      = out_status_reg;
    assign rsp_value_out   = out_value_reg;
    assign rsp_found_index = out_found_reg;
    assign rsp_entry_count = out_count_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(CAPACITY))
        else $error("entry count above capacity");

    a_empty_head: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> (head_reg == '0))
        else $error("head not at zero while empty");

    a_write_port: assert property (@(posedge clk) disable iff (!rst_n)
        pend_v_reg |-> !cmd_writes)
        else $error("shift write collides with a commanded write");

    a_walk_done: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> !pend_v_reg && !cmp_v_reg)
        else $error("result committed with a walk still in flight");

endmodule

// ===== hw/rtl/ring_buffer_indexed_array.sv =====
// ----------------------------------------------------------------------------
// ring_buffer_indexed_array
// Ordered list of words in a circular store with get, set, indexed insert
// and remove, exchange, first/last search within a span, and clear.
// ----------------------------------------------------------------------------
// One request is worked at a time over a word memory with one read port
// and one write port (one read and one write per cycle, registered read).
// Each request is checked first; get and set then access their entry, and
// exchange reads both entries and writes them back swapped. Insert and
// remove shift the entries on the shorter side of the index (at most half
// the entries); a find scans the span up to the first match, or to its end
// when it holds no match. A new request is accepted while the previous
// result still waits in the output register. The store needs no clearing
// after reset; entries are only read below the entry count.
// ----------------------------------------------------------------------------
module ring_buffer_indexed_array import rbia_pkg::*;
#(
    parameter int CAPACITY   = DEF_CAPACITY,
    parameter int WORD_WIDTH = DEF_WORD_WIDTH
)
(
    input  logic       clk,
    input  logic       rst_n,
    rbia_req_if.sink   request,
    rbia_rsp_if.source result
);

    ctrl_cmd_t  cmd;
    dp_status_t dp;
    logic       req_ready;

    // Sequencer
    rbia_controller u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (request.valid),
        .req_ready (req_ready),
        .dp        (dp),
        .cmd       (cmd)
    );

    // Store, pointers and result register
    rbia_datapath #(
        .CAPACITY   (CAPACITY),
        .WORD_WIDTH (WORD_WIDTH)
    ) u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .status           (dp),
        .req_op           (request.op),
        .req_index        (request.index),
        .req_second_index (request.second_index),
        .req_span_length  (request.span_length),
        .req_value_in     (request.value_in),
        .rsp_ready        (result.ready),
        .rsp_valid        (result.valid),
        .rsp_status       (result.status),
        .rsp_value_out    (result.value_out),
        .rsp_found_index  (result.found_index),
        .rsp_entry_count  (result.entry_count)
    );

    assign request.ready = req_ready;

endmodule
